>>> src/otp_pkg.sv
package otp_pkg;

	localparam int CODE_DIGITS_DEF = 6;
	localparam int CODE_W = 20;
	localparam int KEY_HI_W = 16;
	localparam int KEY_LO_W = 64;
	localparam int VAL_W = 64;
	localparam int CFG_W = 64;
	localparam int ROUNDS = 80;
	localparam logic [0:0] REG_KEY_UPPER = 1'b0;
	localparam logic [0:0] REG_KEY_LOWER = 1'b1;
	localparam logic [7:0] IPAD = 8'h36;
	localparam logic [7:0] OPAD = 8'h5c;
	localparam logic [31:0] H0 = 32'h67452301;
	localparam logic [31:0] H1 = 32'hefcdab89;
	localparam logic [31:0] H2 = 32'h98badcfe;
	localparam logic [31:0] H3 = 32'h10325476;
	localparam logic [31:0] H4 = 32'hc3d2e1f0;

	typedef struct packed {
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] c;
		logic [31:0] d;
		logic [31:0] e;
	} sha_st_t;

	typedef struct packed {
		sha_st_t     st;
		sha_st_t     hin;
		logic [511:0] w;
	} sha_cell_t;

	function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
		rotl = (x << n) | (x >> (32 - n));
	endfunction

	function automatic sha_st_t sha_init();
		sha_st_t s;
		s.a = H0; s.b = H1; s.c = H2; s.d = H3; s.e = H4;
		return s;
	endfunction

	function automatic sha_st_t sha_add(input sha_st_t x, input sha_st_t y);
		sha_st_t s;
		s.a = x.a + y.a; s.b = x.b + y.b; s.c = x.c + y.c;
		s.d = x.d + y.d; s.e = x.e + y.e;
		return s;
	endfunction

	function automatic logic [511:0] pad_key(input logic [79:0] key, input logic [7:0] p);
		logic [511:0] r;
		r = {{key, 432'd0}} ^ {64{p}};
		return r;
	endfunction

endpackage

>>> src/otp_stream_if.sv
interface otp_stream_if #(parameter int W = 1);
	logic         valid;
	logic         ready;
	logic [W-1:0] data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

>>> src/otp_hmac_sha1_validate_core.sv
// HOTP/TOTP one-time-password checker using HMAC-SHA1 with a 10-byte key.
// Fully pipelined: one transaction is accepted per cycle, and its result
// passes through the time step divide stages, 4 * 80 SHA-1 round cells,
// and the registers for truncation, the modulo quotient estimate and the
// final correction and compare. The pipeline stalls as a whole when the
// output is held. Keys must be written only while idle; the core itself does not enforce it.
module otp_hmac_sha1_validate_core
	import otp_pkg::*;
#(
	parameter int CODE_DIGITS = CODE_DIGITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [0:0]        cfg_index,
	input  logic [CFG_W-1:0]  cfg_wdata,
	otp_stream_if.sink        in_if,
	otp_stream_if.source      out_if
);
	localparam logic [31:0] MODV = 32'(10 ** CODE_DIGITS);
	localparam int SW = CODE_W + 160;

	logic [KEY_HI_W-1:0] key_upper_q;
	logic [KEY_LO_W-1:0] key_lower_q;
	logic [79:0] key;
	logic en;

	assign key = {key_upper_q, key_lower_q};
	assign en = !out_if.valid || out_if.ready;
	assign in_if.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_upper_q <= '0;
			key_lower_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_KEY_UPPER: key_upper_q <= cfg_wdata[KEY_HI_W-1:0];
				REG_KEY_LOWER: key_lower_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// stage 1: reciprocal multiply for value / 30, partial products
	logic        mode_s1, v_s1;
	logic [VAL_W-1:0] mv_s1;
	logic [CODE_W-1:0] cand_s1;
	// q = floor(x/30) = floor(x/2 / 15); x/2 < 2^63, use 2^67/15 ceil
	localparam logic [67:0] RECIP = 68'h8888888888888889; // ceil(2^67/15)

	logic [63:0] pm_s1 [4];

	// split multiply: 64x64 as four 32x32 products, registered
	logic [63:0] hx;
	assign hx = {1'b0, in_if.data[CODE_W+1 +: 63]};
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= in_if.valid;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			mode_s1 <= in_if.data[CODE_W+VAL_W];
			mv_s1   <= in_if.data[CODE_W +: VAL_W];
			cand_s1 <= in_if.data[CODE_W-1:0];
			pm_s1[0] <= hx[31:0]  * RECIP[31:0];
			pm_s1[1] <= hx[31:0]  * RECIP[63:32];
			pm_s1[2] <= hx[63:32] * RECIP[31:0];
			pm_s1[3] <= hx[63:32] * RECIP[63:32];
		end
	end

	// stage 2: sum partial products, shift by 67
	logic v_s2;
	logic [VAL_W-1:0] msg_s2;
	logic [CODE_W-1:0] cand_s2;
	logic [127:0] prod;
	assign prod = {64'd0, pm_s1[0]} + ({64'd0, pm_s1[1]} << 32) +
		({64'd0, pm_s1[2]} << 32) + ({64'd0, pm_s1[3]} << 64);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (en) v_s2 <= v_s1;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			msg_s2  <= mode_s1 ? {3'd0, prod[127:67]} : mv_s1;
			cand_s2 <= cand_s1;
		end
	end

	// four sha-1 compressions in a row
	sha_st_t h_a, h_b, h_c, h_d;
	logic va, vb, vc, vd;
	logic [SW-1:0] sa, sb, sc, sd;
	logic [511:0] blk_b, blk_d;

	otp_sha1_chain #(.SIDE_W(SW)) u_in0 (
		.clk(clk), .arst_n(arst_n), .en(en), .vin(v_s2), .hin(sha_init()),
		.blk(pad_key(key, IPAD)), .sin({cand_s2, 96'd0, msg_s2}),
		.vout(va), .hout(h_a), .sout(sa));

	assign blk_b = {sa[63:0], 8'h80, 376'd0, 64'd576};
	otp_sha1_chain #(.SIDE_W(SW)) u_in1 (
		.clk(clk), .arst_n(arst_n), .en(en), .vin(va), .hin(h_a),
		.blk(blk_b), .sin(sa), .vout(vb), .hout(h_b), .sout(sb));

	otp_sha1_chain #(.SIDE_W(SW)) u_out0 (
		.clk(clk), .arst_n(arst_n), .en(en), .vin(vb), .hin(sha_init()),
		.blk(pad_key(key, OPAD)), .sin({sb[SW-1 -: CODE_W], h_b}),
		.vout(vc), .hout(h_c), .sout(sc));

	assign blk_d = {sc[159:0], 8'h80, 280'd0, 64'd672};
	otp_sha1_chain #(.SIDE_W(SW)) u_out1 (
		.clk(clk), .arst_n(arst_n), .en(en), .vin(vc), .hin(h_c),
		.blk(blk_d), .sin(sc), .vout(vd), .hout(h_d), .sout(sd));

	// truncation
	logic [159:0] mac;
	logic [3:0] off;
	logic [31:0] tr;
	assign mac = h_d;
	assign off = mac[3:0];
	assign tr = mac[159 - 8 * off -: 32];

	logic v_t1;
	logic [30:0] tr_t1;
	logic [CODE_W-1:0] cand_t1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_t1 <= 1'b0;
		else if (en) v_t1 <= vd;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			tr_t1   <= tr[30:0];
			cand_t1 <= sd[SW-1 -: CODE_W];
		end
	end

	// modulo: reciprocal quotient estimate then correction
	localparam int QS = 51;
	localparam logic [31:0] MREC = 32'((64'd1 << QS) / 64'(MODV) + 64'd1);
	logic [63:0] qp;
	assign qp = {33'd0, tr_t1} * {32'd0, MREC};
	logic v_t2;
	logic [30:0] tr_t2;
	logic [31:0] q_t2;
	logic [CODE_W-1:0] cand_t2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_t2 <= 1'b0;
		else if (en) v_t2 <= v_t1;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			tr_t2   <= tr_t1;
			q_t2    <= {19'd0, qp[63:QS]};
			cand_t2 <= cand_t1;
		end
	end

	logic [63:0] qm;
	logic [63:0] rr;
	logic [31:0] rem;
	assign qm = 64'(q_t2) * 64'(MODV);
	assign rr = 64'(tr_t2) - qm;
	assign rem = rr[63] ? 32'(rr + 64'(MODV)) : (rr[31:0] >= MODV ? rr[31:0] - MODV : rr[31:0]);

	logic [CODE_W-1:0] code;
	assign code = rem[CODE_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_if.valid <= 1'b0;
		else if (en) out_if.valid <= v_t2;
	end
	always_ff @(posedge clk) begin
		if (en) out_if.data <= {code == cand_t2, code};
	end
endmodule

>>> src/otp_round_cell.sv
module otp_round_cell
	import otp_pkg::*;
#(
	parameter int RND = 0,
	parameter int SIDE_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              vin,
	input  sha_cell_t         din,
	input  logic [SIDE_W-1:0] sin,
	output logic              vout,
	output sha_cell_t         dout,
	output logic [SIDE_W-1:0] sout
);
	logic [31:0] f, k, t, wn;
	sha_cell_t nx;

	always_comb begin
		if (RND < 20) begin
			f = (din.st.b & din.st.c) | (~din.st.b & din.st.d);
			k = 32'h5a827999;
		end else if (RND < 40) begin
			f = din.st.b ^ din.st.c ^ din.st.d;
			k = 32'h6ed9eba1;
		end else if (RND < 60) begin
			f = (din.st.b & din.st.c) | (din.st.b & din.st.d) | (din.st.c & din.st.d);
			k = 32'h8f1bbcdc;
		end else begin
			f = din.st.b ^ din.st.c ^ din.st.d;
			k = 32'hca62c1d6;
		end
		t = rotl(din.st.a, 5) + f + din.st.e + k + din.w[511:480];
		wn = rotl(din.w[95:64] ^ din.w[255:224] ^ din.w[447:416] ^ din.w[511:480], 1);
		nx.hin = din.hin;
		nx.st.a = t;
		nx.st.b = din.st.a;
		nx.st.c = rotl(din.st.b, 30);
		nx.st.d = din.st.c;
		nx.st.e = din.st.d;
		nx.w = {din.w[479:0], wn};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vout <= 1'b0;
		end else if (en) begin
			vout <= vin;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dout <= nx;
			sout <= sin;
		end
	end
endmodule

>>> src/otp_sha1_chain.sv
module otp_sha1_chain
	import otp_pkg::*;
#(
	parameter int SIDE_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              vin,
	input  sha_st_t           hin,
	input  logic [511:0]      blk,
	input  logic [SIDE_W-1:0] sin,
	output logic              vout,
	output sha_st_t           hout,
	output logic [SIDE_W-1:0] sout
);
	logic              v [ROUNDS+1];
	sha_cell_t         d [ROUNDS+1];
	logic [SIDE_W-1:0] s [ROUNDS+1];

	assign v[0] = vin;
	assign s[0] = sin;
	assign d[0] = '{st: hin, hin: hin, w: blk};

	for (genvar i = 0; i < ROUNDS; i++) begin : g_cell
		otp_round_cell #(.RND(i), .SIDE_W(SIDE_W)) u_cell (
			.clk(clk), .arst_n(arst_n), .en(en),
			.vin(v[i]), .din(d[i]), .sin(s[i]),
			.vout(v[i+1]), .dout(d[i+1]), .sout(s[i+1])
		);
	end

	assign vout = v[ROUNDS];
	assign sout = s[ROUNDS];
	assign hout = sha_add(d[ROUNDS].st, d[ROUNDS].hin);
endmodule
